@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of the tokenizer core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define QDT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define QDT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/qdt_pkg.sv @@
// Package of the quoted delimiter tokenizer: word types, register indexes,
// default sizes and the queue entry passed from front to back. No dependencies.
package qdt_pkg;

  localparam int MaxLengthDefault = 65535;
  localparam int SetSizeDefault   = 8;
  localparam int MaxTokensDefault = 64;

  localparam int CfgDataW  = 64;
  localparam int CountW    = 4;
  localparam int LimitW    = 7;
  localparam int PosW      = 16;
  localparam int TokNumW   = 6;
  localparam int CharW     = 8;

  localparam logic [LimitW-1:0] DefaultLimit = 7'd60;

  localparam int MidDepth = 2;
  localparam int OutDepth = 2;

  typedef enum logic [2:0] {
    CfgDelimChars = 3'd0,
    CfgDelimCount = 3'd1,
    CfgQuoteChars = 3'd2,
    CfgQuoteCount = 3'd3,
    CfgTokenLimit = 3'd4
  } qdt_cfg_idx_e;

  typedef struct packed {
    logic             mode;
    logic [CharW-1:0] char_code;
  } qdt_in_t;

  typedef struct packed {
    logic [PosW-1:0]    token_start;
    logic [PosW-1:0]    token_length;
    logic [TokNumW-1:0] token_number;
    logic               last_token;
    logic               empty_input;
    logic               too_long;
  } qdt_out_t;

  // Classified character, as queued between front and back.
  typedef struct packed {
    logic end_of_string;
    logic is_delim;
    logic is_quote;
  } qdt_class_t;

endpackage

@@ rtl/core/quoted_delimiter_tokenizer_core.sv @@
// Top level of the quoted delimiter tokenizer. Depends on qdt_pkg, qdt_fifo,
// qdt_front and qdt_back.
//
// The core takes a string one character word per cycle while full is low,
// closed by an end word, and emits one result word for every token cut at a
// delimiter plus one for the end word (the final token, or an empty-input flag
// when no character came). Both sides behave like queues: push/full on the
// input, empty/pop on the results. A character word is classified against the
// delimiter and quote sets as it is accepted, sits in a two-entry queue, and
// the back end updates the token state and writes the result into a two-entry
// output queue. The sustained rate is one word per cycle while results are
// popped, set by the back end updating its state for each word it takes; an
// accepted word is registered in the middle queue and its result in the output
// queue, and results that are not popped fill the output queue and then the
// middle queue before full rises. No clearing pass is needed after reset.
// Registers are written through the plain write port and should only be
// changed while the core is idle.
module quoted_delimiter_tokenizer_core #(
  parameter int MAX_LENGTH = qdt_pkg::MaxLengthDefault,
  parameter int SET_SIZE   = qdt_pkg::SetSizeDefault,
  parameter int TOKEN_CAP  = qdt_pkg::MaxTokensDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Character words in.
  input  logic                          push,
  output logic                          full,
  input  qdt_pkg::qdt_in_t              in_word_i,
  // Result words out.
  output logic                          empty,
  input  logic                          pop,
  output qdt_pkg::qdt_out_t             out_word_o,
  // Register write port.
  input  logic                          cfg_we_i,
  input  qdt_pkg::qdt_cfg_idx_e         cfg_idx_i,
  input  logic [qdt_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int SetW   = 8 * SET_SIZE;
  localparam int ClassW = $bits(qdt_pkg::qdt_class_t);
  localparam int OutW   = $bits(qdt_pkg::qdt_out_t);

  // Register file. Only the bytes that the sets can use are stored.
  logic [SetW-1:0]                 delim_chars_q;
  logic [qdt_pkg::CountW-1:0]      delim_count_q;
  logic [SetW-1:0]                 quote_chars_q;
  logic [qdt_pkg::CountW-1:0]      quote_count_q;
  logic [qdt_pkg::LimitW-1:0]      token_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_chars_q <= '0;
      delim_count_q <= '0;
      quote_chars_q <= '0;
      quote_count_q <= '0;
      token_limit_q <= qdt_pkg::DefaultLimit;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qdt_pkg::CfgDelimChars: delim_chars_q <= cfg_data_i[SetW-1:0];
        qdt_pkg::CfgDelimCount: delim_count_q <= cfg_data_i[qdt_pkg::CountW-1:0];
        qdt_pkg::CfgQuoteChars: quote_chars_q <= cfg_data_i[SetW-1:0];
        qdt_pkg::CfgQuoteCount: quote_count_q <= cfg_data_i[qdt_pkg::CountW-1:0];
        qdt_pkg::CfgTokenLimit: token_limit_q <= cfg_data_i[qdt_pkg::LimitW-1:0];
        default: begin
          // Writes to unknown indexes are dropped.
        end
      endcase
    end
  end

  // Front end: classify the word as it is accepted.
  qdt_pkg::qdt_class_t front_class;
  qdt_pkg::qdt_class_t mid_class;
  logic                mid_empty;
  logic                out_full;
  logic                back_take;
  logic                res_valid;
  qdt_pkg::qdt_out_t   res_word;

  qdt_front #(
    .SET_SIZE (SET_SIZE)
  ) u_front (
    .in_word_i     (in_word_i),
    .delim_chars_i (delim_chars_q),
    .delim_count_i (delim_count_q),
    .quote_chars_i (quote_chars_q),
    .quote_count_i (quote_count_q),
    .class_o       (front_class)
  );

  // Middle queue decouples acceptance from the state update.
  qdt_fifo #(
    .WIDTH (ClassW),
    .DEPTH (qdt_pkg::MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_class),
    .full_o  (full),
    .pop_i   (back_take),
    .rdata_o (mid_class),
    .empty_o (mid_empty)
  );

  // The back end only consumes a word when its result has somewhere to go.
  assign back_take = !mid_empty && !out_full;

  qdt_back #(
    .MAX_LENGTH (MAX_LENGTH),
    .TOKEN_CAP  (TOKEN_CAP)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (back_take),
    .class_i       (mid_class),
    .token_limit_i (token_limit_q),
    .res_valid_o   (res_valid),
    .res_o         (res_word)
  );

  // Output queue holds finished result words until they are popped.
  qdt_fifo #(
    .WIDTH (OutW),
    .DEPTH (qdt_pkg::OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (res_word),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_word_o),
    .empty_o (empty)
  );

endmodule

@@ rtl/core/qdt_fifo.sv @@
// Small first-in first-out queue of registers with count-based full/empty.
// No package dependencies; used for the middle and result queues.
module qdt_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/core/qdt_front.sv @@
// Front end of the tokenizer: matches each incoming character against the
// delimiter and quote sets. Depends on qdt_pkg.
module qdt_front #(
  parameter int SET_SIZE = qdt_pkg::SetSizeDefault
) (
  input  qdt_pkg::qdt_in_t                 in_word_i,
  input  logic [8*SET_SIZE-1:0]            delim_chars_i,
  input  logic [qdt_pkg::CountW-1:0]       delim_count_i,
  input  logic [8*SET_SIZE-1:0]            quote_chars_i,
  input  logic [qdt_pkg::CountW-1:0]       quote_count_i,
  output qdt_pkg::qdt_class_t              class_o
);

  logic [qdt_pkg::CountW-1:0] delim_n, quote_n;
  logic                       delim_hit, quote_hit;

  // Counts above the set size only use the bytes that are stored.
  assign delim_n = (delim_count_i > qdt_pkg::CountW'(SET_SIZE)) ?
                   qdt_pkg::CountW'(SET_SIZE) : delim_count_i;
  assign quote_n = (quote_count_i > qdt_pkg::CountW'(SET_SIZE)) ?
                   qdt_pkg::CountW'(SET_SIZE) : quote_count_i;

  always_comb begin
    delim_hit = 1'b0;
    quote_hit = 1'b0;
    for (int i = 0; i < SET_SIZE; i++) begin
      if ((qdt_pkg::CountW'(i) < delim_n) &&
          (delim_chars_i[8*i +: 8] == in_word_i.char_code)) begin
        delim_hit = 1'b1;
      end
      if ((qdt_pkg::CountW'(i) < quote_n) &&
          (quote_chars_i[8*i +: 8] == in_word_i.char_code)) begin
        quote_hit = 1'b1;
      end
    end
  end

  assign class_o.end_of_string = in_word_i.mode;
  assign class_o.is_delim      = delim_hit && !in_word_i.mode;
  assign class_o.is_quote      = quote_hit && !in_word_i.mode;

endmodule

@@ rtl/core/qdt_back.sv @@
// Back end of the tokenizer: keeps the per-string state, cuts tokens and
// builds result words. Depends on qdt_pkg.
module qdt_back #(
  parameter int MAX_LENGTH = qdt_pkg::MaxLengthDefault,
  parameter int TOKEN_CAP  = qdt_pkg::MaxTokensDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  qdt_pkg::qdt_class_t         class_i,
  input  logic [qdt_pkg::LimitW-1:0]  token_limit_i,
  output logic                        res_valid_o,
  output qdt_pkg::qdt_out_t           res_o
);

  localparam int PW = qdt_pkg::PosW;
  localparam int LW = qdt_pkg::LimitW;
  localparam logic [PW-1:0] PosMax = PW'(MAX_LENGTH);

  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] tb_q, tb_d;
  logic [PW-1:0] qe_q, qe_d;
  logic          qev_q, qev_d;
  logic          inq_q, inq_d;
  logic [LW-1:0] td_q, td_d;
  logic          ovf_q, ovf_d;

  logic [LW-1:0] limit;
  logic [LW-1:0] td_after_cut;
  logic [PW-1:0] next_begin;
  logic [PW-1:0] cut_end;
  logic [PW-1:0] last_end;
  logic          cut, open_quote;

  function automatic logic [PW-1:0] tok_len(logic [PW-1:0] endpos, logic [PW-1:0] begpos);
    return (endpos >= begpos) ? endpos - begpos : '0;
  endfunction

  always_comb begin
    if (token_limit_i == '0) begin
      limit = qdt_pkg::DefaultLimit;
    end else if (token_limit_i > LW'(TOKEN_CAP)) begin
      limit = LW'(TOKEN_CAP);
    end else begin
      limit = token_limit_i;
    end
  end

  assign next_begin   = (pos_q == PosMax) ? PosMax : pos_q + PW'(1);
  assign cut          = class_i.is_delim &&
                        ({1'b0, td_q} + (LW+1)'(1) < {1'b0, limit});
  assign td_after_cut = cut ? td_q + LW'(1) : td_q;
  assign open_quote   = class_i.is_quote &&
                        ({1'b0, td_after_cut} + (LW+1)'(1) < {1'b0, limit});
  assign cut_end      = qev_q ? qe_q : pos_q;
  assign last_end     = (!inq_q && qev_q) ? qe_q : pos_q;

  always_comb begin
    pos_d       = pos_q;
    tb_d        = tb_q;
    qe_d        = qe_q;
    qev_d       = qev_q;
    inq_d       = inq_q;
    td_d        = td_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (take_i) begin
      if (class_i.end_of_string) begin
        res_valid_o = 1'b1;
        if (pos_q == '0) begin
          res_o.empty_input = 1'b1;
        end else begin
          res_o.token_start  = tb_q;
          res_o.token_length = tok_len(last_end, tb_q);
          res_o.token_number = td_q[qdt_pkg::TokNumW-1:0];
          res_o.last_token   = 1'b1;
          res_o.too_long     = ovf_q;
        end
        pos_d = '0;
        tb_d  = '0;
        qe_d  = '0;
        qev_d = 1'b0;
        inq_d = 1'b0;
        td_d  = '0;
        ovf_d = 1'b0;
      end else begin
        ovf_d = ovf_q || (pos_q == PosMax);
        pos_d = (pos_q == PosMax) ? pos_q : pos_q + PW'(1);
        if (inq_q) begin
          if (class_i.is_quote) begin
            qe_d  = pos_q;
            qev_d = 1'b1;
            inq_d = 1'b0;
          end
        end else begin
          if (cut) begin
            res_valid_o        = 1'b1;
            res_o.token_start  = tb_q;
            res_o.token_length = tok_len(cut_end, tb_q);
            res_o.token_number = td_q[qdt_pkg::TokNumW-1:0];
            res_o.too_long     = ovf_d;
            td_d               = td_after_cut;
            tb_d               = next_begin;
            qev_d              = 1'b0;
          end
          if (open_quote) begin
            tb_d  = next_begin;
            inq_d = 1'b1;
            qev_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      tb_q  <= '0;
      qe_q  <= '0;
      qev_q <= 1'b0;
      inq_q <= 1'b0;
      td_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      tb_q  <= tb_d;
      qe_q  <= qe_d;
      qev_q <= qev_d;
      inq_q <= inq_d;
      td_q  <= td_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

@@ rtl/core/qdt_checker.sv @@
// Port-level checker for the tokenizer core, bound to the top level.
// Depends on qdt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qdt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input qdt_pkg::qdt_out_t out_word_o
);

  // Nothing is waiting right after reset.
  `QDT_ASSERT_ALWAYS(a_empty_after_reset, clk_i, !rst_ni |=> empty, "result queue not empty after reset")

  // A result that is not taken stays on the ports unchanged.
  `QDT_ASSERT(a_hold_result, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_word_o)), "waiting result changed")

  // An empty-string result carries no token information.
  `QDT_ASSERT(a_empty_fields, clk_i, rst_ni, (!empty && out_word_o.empty_input) |-> (out_word_o.token_start == '0 && out_word_o.token_length == '0 && out_word_o.token_number == '0 && !out_word_o.last_token && !out_word_o.too_long), "empty-input result has token fields set")

  // A token cut at a delimiter can never be the highest possible index.
  `QDT_ASSERT(a_cut_index, clk_i, rst_ni, (!empty && !out_word_o.last_token && !out_word_o.empty_input) |-> (out_word_o.token_number != 6'd63), "cut token index out of range")

endmodule

bind quoted_delimiter_tokenizer_core qdt_checker u_qdt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_word_o (out_word_o)
);

@@ bench/quoted_delimiter_tokenizer_core_tb.sv @@
// Self-checking bench for quoted_delimiter_tokenizer_core: a queue-fed word driver,
// a result monitor and a word-level token predictor kept inside this module.
// Depends on qdt_pkg and the core RTL only.
`timescale 1ns / 1ps

module quoted_delimiter_tokenizer_core_tb;
  import qdt_pkg::*;

  localparam int MaxLen     = MaxLengthDefault;
  localparam int SetSize    = SetSizeDefault;
  localparam int MaxTok     = MaxTokensDefault;
  localparam int LongHold   = 150;     // receiver hold-off used to fill the core up
  localparam int SettleWait = 8;       // settling wait for words still in flight after a drain
  localparam int CycleLimit = 60000;   // watchdog bound on the whole run
  localparam int PerSetting = 165;     // six settings give roughly 1000 random words

  // A register index that the core does not implement; writes to it must be ignored.
  localparam qdt_cfg_idx_e UnusedIdx = qdt_cfg_idx_e'(3'd7);

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                push       = 1'b0;
  logic                full;
  qdt_in_t             in_word_i  = '0;
  logic                empty;
  logic                pop        = 1'b0;
  qdt_out_t            out_word_o;
  logic                cfg_we_i   = 1'b0;
  qdt_cfg_idx_e        cfg_idx_i  = CfgDelimChars;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  quoted_delimiter_tokenizer_core #(
    .MAX_LENGTH(MaxLen),
    .SET_SIZE  (SetSize),
    .TOKEN_CAP (MaxTok)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_word_i (in_word_i),
    .empty     (empty),
    .pop       (pop),
    .out_word_o(out_word_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Words waiting to be offered, and token words the core still owes us.
  qdt_in_t  pending_words[$];
  qdt_out_t expected_tokens[$];

  int failures      = 0;
  int send_idle_pct = 29;
  int recv_idle_pct = 59;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  // Predictor copy of the registers, updated whenever the bench writes one.
  logic [CfgDataW-1:0] delim_set  = '0;
  logic [CountW-1:0]   delim_size = '0;
  logic [CfgDataW-1:0] quote_set  = '0;
  logic [CountW-1:0]   quote_size = '0;
  logic [LimitW-1:0]   limit_reg  = DefaultLimit;

  // Predictor copy of the per-string scan state. Everything returns to zero
  // after each end word, so these initial values double as the reset state.
  logic [PosW-1:0]   str_pos     = '0;
  logic [PosW-1:0]   tok_begin   = '0;
  logic [PosW-1:0]   q_end       = '0;
  logic              q_end_valid = 1'b0;
  logic              in_quote    = 1'b0;
  logic [LimitW-1:0] tok_done    = '0;
  logic              ovf         = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Only the first min(size, SET_SIZE) bytes of a set take part in matching.
  function automatic bit in_byte_set(logic [CfgDataW-1:0] set_bytes, logic [CountW-1:0] size,
                                     logic [CharW-1:0] c);
    int n;
    n = (int'(size) > SetSize) ? SetSize : int'(size);
    for (int i = 0; i < n; i++) begin
      if (set_bytes[8*i +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Builds the result word for the token that runs from tok_begin up to stop.
  // A closing quote can sit at the token start, which gives length zero.
  function automatic qdt_out_t cut_token(logic [PosW-1:0] stop, logic last);
    qdt_out_t t;
    t = '0;
    t.token_start  = tok_begin;
    t.token_length = (stop >= tok_begin) ? stop - tok_begin : '0;
    t.token_number = tok_done[TokNumW-1:0];
    t.last_token   = last;
    t.too_long     = ovf;
    return t;
  endfunction

  // Advances the scan state by one accepted word and queues any token it cuts.
  task automatic predict_tokens(qdt_in_t w);
    qdt_out_t tok;
    int       lim;
    int       p;
    lim = (limit_reg == 0) ? int'(DefaultLimit) : int'(limit_reg);
    if (lim > MaxTok) lim = MaxTok;

    if (w.mode) begin
      // End of string: the final token, or the empty flag when no byte came.
      tok = '0;
      if (str_pos == 0) tok.empty_input = 1'b1;
      else tok = cut_token((!in_quote && q_end_valid) ? q_end : str_pos, 1'b1);
      expected_tokens.push_back(tok);
      str_pos     = '0;
      tok_begin   = '0;
      q_end       = '0;
      q_end_valid = 1'b0;
      in_quote    = 1'b0;
      tok_done    = '0;
      ovf         = 1'b0;
    end else begin
      // Offsets stop at MAX_LENGTH; once a byte lands there the string is too long.
      p = int'(str_pos);
      if (p >= MaxLen) ovf = 1'b1;
      else str_pos = str_pos + PosW'(1);

      if (in_quote) begin
        // Inside a quote only another quote byte matters, and it is never a cut.
        if (in_byte_set(quote_set, quote_size, w.char_code)) begin
          q_end       = PosW'(p);
          q_end_valid = 1'b1;
          in_quote    = 1'b0;
        end
      end else begin
        // A byte in both sets cuts first and then opens a quote, each only while
        // the token budget leaves room for a further token after this one.
        if (in_byte_set(delim_set, delim_size, w.char_code) && int'(tok_done) + 1 < lim) begin
          expected_tokens.push_back(cut_token(q_end_valid ? q_end : PosW'(p), 1'b0));
          tok_done    = tok_done + LimitW'(1);
          tok_begin   = PosW'((p + 1 > MaxLen) ? MaxLen : p + 1);
          q_end_valid = 1'b0;
        end
        if (in_byte_set(quote_set, quote_size, w.char_code) && int'(tok_done) + 1 < lim) begin
          tok_begin   = PosW'((p + 1 > MaxLen) ? MaxLen : p + 1);
          in_quote    = 1'b1;
          q_end_valid = 1'b0;
        end
      end
    end
  endtask

  function automatic string token_text(qdt_out_t t);
    return $sformatf("start=%0d len=%0d num=%0d last=%0b empty=%0b too_long=%0b",
                     t.token_start, t.token_length, t.token_number, t.last_token,
                     t.empty_input, t.too_long);
  endfunction

  task automatic check_token(qdt_out_t got);
    qdt_out_t want;
    if (expected_tokens.size() == 0) begin
      $display("%0t: token word with none expected, expected none, actual %s", $time,
               token_text(got));
      failures++;
    end else begin
      want = expected_tokens.pop_front();
      if (got !== want) begin
        $display("%0t: token mismatch, expected %s, actual %s", $time, token_text(want),
                 token_text(got));
        failures++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued words with random gaps. A word that meets full stays
  // on the port unchanged until the core takes it, and the prediction runs on
  // the edge at which it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      in_word_i <= '0;
    end else begin
      if (push && !full) predict_tokens(in_word_i);
      if (!push || !full) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push      <= 1'b1;
          in_word_i <= pending_words.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: pops with random stalls and checks every accepted token word. A new
  // hold request starts a long stretch with pop low, counted here, so that the
  // output and middle queues fill and full rises toward the driver.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_token(out_word_o);
      if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        hold_left   <= LongHold;
        pop         <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_char(logic [CharW-1:0] c);
    qdt_in_t w;
    w.mode      = 1'b0;
    w.char_code = c;
    pending_words.push_back(w);
  endfunction

  // The byte of an end word is ignored by the core, so it is random here.
  function automatic void push_end();
    qdt_in_t w;
    w.mode      = 1'b1;
    w.char_code = CharW'($urandom_range(255));
    pending_words.push_back(w);
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endfunction

  // One byte out of the valid part of a set, or any byte when the set is empty.
  function automatic logic [CharW-1:0] set_pick(logic [CfgDataW-1:0] set_bytes,
                                                logic [CountW-1:0] size);
    int n;
    n = (int'(size) > SetSize) ? SetSize : int'(size);
    if (n == 0) return CharW'($urandom_range(255));
    return set_bytes[8*$urandom_range(n - 1) +: 8];
  endfunction

  // Random content biased toward the active sets so cuts and quotes are frequent.
  function automatic logic [CharW-1:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 25) return set_pick(delim_set, delim_size);
    if (r < 40) return set_pick(quote_set, quote_size);
    if (r < 44) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    return CharW'($urandom_range(1, 255));
  endfunction

  // Queues one terminated string and returns the number of words it took.
  // Most strings are short; a few are long enough to run out the token budget.
  function automatic int queue_random_string();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(12);
    for (int i = 0; i < len; i++) push_char(pick_char());
    push_end();
    return len + 1;
  endfunction

  // Drained means nothing left to offer and no token word outstanding. Sampled on
  // the falling edge so the driver's and monitor's updates have all settled, then
  // the SettleWait delay covers words still in flight that cut no token.
  task automatic wait_until_drained();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || push || expected_tokens.size() != 0);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // Must be called right after a rising edge while the core is idle. The write
  // enable stays high across back-to-back writes; the caller lowers it.
  task automatic write_register(qdt_cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgDelimChars: delim_set  = data;
      CfgDelimCount: delim_size = data[CountW-1:0];
      CfgQuoteChars: quote_set  = data;
      CfgQuoteCount: quote_size = data[CountW-1:0];
      CfgTokenLimit: limit_reg  = data[LimitW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Register settings for the random phases, from sparse to saturated. Counts and
  // limits above their ranges check the clamping, and the last setting shares
  // bytes between the two sets so dual-role bytes come up often.
  task automatic load_setting(int s);
    logic [CfgDataW-1:0] d;
    logic [CfgDataW-1:0] q;
    logic [CountW-1:0]   dn;
    logic [CountW-1:0]   qn;
    logic [LimitW-1:0]   lim;
    d = {$urandom, $urandom};
    q = {$urandom, $urandom};
    case (s)
      0: begin d = 64'h2E2D_7C09_3B3A_2C20; dn = 4'd8;  q = 64'h2722; qn = 4'd2;  lim = 7'd64; end
      1: begin d = '1;                      dn = 4'd15; q = '0;      qn = 4'd8;  lim = 7'd2;  end
      2: begin                              dn = 4'd3;               qn = 4'd15; lim = 7'd0;  end
      3: begin                              dn = 4'd1;               qn = 4'd0;  lim = 7'd127; end
      4: begin                              dn = 4'd5;               qn = 4'd1;  lim = 7'd5;  end
      default: begin                        dn = 4'd8;  q = d >> 16; qn = 4'd4;  lim = 7'd60; end
    endcase
    write_register(CfgDelimChars, d);
    write_register(CfgDelimCount, CfgDataW'(dn));
    write_register(CfgQuoteChars, q);
    write_register(CfgQuoteCount, CfgDataW'(qn));
    write_register(CfgTokenLimit, CfgDataW'(lim));
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int queued;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: no delimiters, no quotes. An empty string first, then a
    // string that cannot be cut, with a zero byte inside it.
    push_end();
    push_char("a");
    push_char(8'h00);
    push_end();
    wait_until_drained();

    // Comma, space, zero and all-ones byte delimit; double quote, apostrophe and
    // comma quote, so comma plays both roles. Byte seven of the delimiter set is
    // 'm', which stays outside the set until the count grows. A limit of zero
    // selects the default of sixty, and the write to the unused index must not
    // disturb anything.
    write_register(CfgDelimChars, 64'h6D3B_3A7C_FF00_202C);
    write_register(CfgDelimCount, 64'd4);
    write_register(CfgQuoteChars, 64'h2C_2722);
    write_register(CfgQuoteCount, 64'd3);
    write_register(CfgTokenLimit, 64'd0);
    write_register(UnusedIdx, '1);
    cfg_we_i <= 1'b0;

    // Plain cut, a quote with a space inside, the closing quote followed by a
    // dropped byte, zero and all-ones delimiters, a dual-role comma, and an
    // apostrophe left open up to the end word.
    queue_text("a,\"b \"x");
    push_char(8'h00);
    push_char(8'hFF);
    queue_text(",q,'z");
    push_end();

    // Leave a string half done, then widen the delimiter count past the set size
    // so 'm' starts to delimit mid-string, with a limit above the maximum.
    queue_text("km");
    wait_until_drained();
    write_register(CfgDelimCount, 64'd15);
    write_register(CfgTokenLimit, 64'd127);
    cfg_we_i <= 1'b0;
    queue_text("mk");
    push_end();
    wait_until_drained();

    // With a limit of one nothing is ever cut or quoted.
    write_register(CfgTokenLimit, 64'd1);
    cfg_we_i <= 1'b0;
    queue_text(",\",a");
    push_end();

    // Random phases: two settings per idling pattern, draining fully before each
    // register change so that the sender also waits out every owed token.
    for (int s = 0; s < 6; s++) begin
      wait_until_drained();
      if (s < 2) begin
        send_idle_pct <= 29;
        recv_idle_pct <= 59;
      end else if (s < 4) begin
        send_idle_pct <= 59;
        recv_idle_pct <= 29;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      load_setting(s);

      if (s == 0) begin
        // Receiver holds off while a delimiter-dense string keeps the sender busy.
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < 40; i++) push_char(set_pick(delim_set, delim_size));
        push_end();
      end

      queued = 0;
      while (queued < PerSetting) queued += queue_random_string();
    end

    wait_until_drained();
    repeat (20) @(posedge clk_i);
    if (expected_tokens.size() != 0) begin
      $display("%0t: %0d token words never arrived, oldest expected %s, actual none", $time,
               expected_tokens.size(), token_text(expected_tokens[0]));
      failures++;
    end
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
